### sv/csort_pkg.sv
package csort_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int MAX_ELEMENTS = 32;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
  } out_item_t;

endpackage

### sv/csort_ram.sv
module csort_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/cocktail_shaker_sorter_core.sv
// Cocktail shaker sorter.
// Input channel (item_valid / item_stall / item): one signed value per item,
// item.last_in closes the set. Items are written into the element RAM at one
// per cycle; once MAX_ELEMENTS are held, further items are dropped, but their
// last_in flag still closes the set. item_stall is high from the closing item
// until the last sorted item has been taken.
// Sorting runs in place in the RAM: forward and backward passes alternate,
// carrying the bubbling element in a register, with one RAM read and one
// write per cycle as a pass runs along its window. The window shrinks to
// the last swap position; a pass with no swap ends the sort.
// Output channel (result_valid / result_stall / result): the set comes out in
// ascending order, result.last_out on the final element. Each item passes
// through a RAM read, a register load and a hand-over; a stall holds the
// output register steady for as long as it lasts.
// Reset (rst, synchronous) empties the set and returns to loading; the RAM
// contents are not cleared, as only entries of the current set are read.
module cocktail_shaker_sorter_core #(
  parameter int MAX_ELEMENTS = csort_pkg::MAX_ELEMENTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  csort_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output csort_pkg::out_item_t result
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int DW = csort_pkg::DATA_WIDTH;

  typedef enum logic [3:0] {
    ST_LOAD, ST_F_PRIME, ST_F_LOADC, ST_F_RUN, ST_F_END,
    ST_B_PRIME, ST_B_LOADC, ST_B_RUN, ST_B_END,
    ST_O_RD, ST_O_LD, ST_O_WAIT
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        lo;
  logic [AW-1:0]        hi;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        k;
  logic [AW-1:0]        last_swap;
  logic                 swapped;
  logic signed [DW-1:0] carry;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  logic          room;
  logic [CW-1:0] count_next;
  logic          fwd_swap;
  logic          bwd_swap;

  csort_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign room       = count < CW'(MAX_ELEMENTS);
  assign count_next = count + CW'(room);
  // Forward pass carries the largest so far upwards, backward the smallest down.
  assign fwd_swap   = carry > $signed(rdata);
  assign bwd_swap   = carry < $signed(rdata);
  assign item_stall = (state != ST_LOAD);

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = carry;
    raddr = idx;
    unique case (state)
      ST_LOAD: begin
        we    = item_valid && room;
        waddr = count[AW-1:0];
        wdata = item.value;
      end
      ST_F_PRIME: raddr = lo;
      ST_F_LOADC: raddr = lo + AW'(1);
      ST_F_RUN: begin
        raddr = idx + AW'(2);
        we    = 1'b1;
        wdata = fwd_swap ? rdata : carry;
      end
      ST_F_END: begin
        we    = 1'b1;
        waddr = hi;
      end
      ST_B_PRIME: raddr = hi;
      ST_B_LOADC: raddr = hi - AW'(1);
      ST_B_RUN: begin
        raddr = idx - AW'(2);
        we    = 1'b1;
        wdata = bwd_swap ? rdata : carry;
      end
      ST_B_END: begin
        we    = 1'b1;
        waddr = lo;
      end
      ST_O_RD: raddr = k;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      count        <= '0;
      lo           <= '0;
      hi           <= '0;
      idx          <= '0;
      k            <= '0;
      last_swap    <= '0;
      swapped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (item_valid) begin
            count <= count_next;
            if (item.last_in) begin
              // Close the set: sort if more than one element is held.
              lo    <= '0;
              hi    <= AW'(count_next - CW'(1));
              k     <= '0;
              state <= (count_next > CW'(1)) ? ST_F_PRIME : ST_O_RD;
            end
          end
        end
        ST_F_PRIME: state <= ST_F_LOADC;
        ST_F_LOADC: begin
          carry   <= $signed(rdata);
          idx     <= lo;
          swapped <= 1'b0;
          state   <= ST_F_RUN;
        end
        ST_F_RUN: begin
          if (fwd_swap) begin
            swapped   <= 1'b1;
            last_swap <= idx;
          end else begin
            carry <= $signed(rdata);
          end
          idx <= idx + AW'(1);
          if (idx + AW'(1) == hi) begin
            state <= ST_F_END;
          end
        end
        ST_F_END: begin
          // Drop to output when nothing moved or the window has closed.
          if (!swapped || last_swap == lo) begin
            k     <= '0;
            state <= ST_O_RD;
          end else begin
            hi    <= last_swap;
            state <= ST_B_PRIME;
          end
        end
        ST_B_PRIME: state <= ST_B_LOADC;
        ST_B_LOADC: begin
          carry   <= $signed(rdata);
          idx     <= hi;
          swapped <= 1'b0;
          state   <= ST_B_RUN;
        end
        ST_B_RUN: begin
          if (bwd_swap) begin
            swapped   <= 1'b1;
            last_swap <= idx;
          end else begin
            carry <= $signed(rdata);
          end
          idx <= idx - AW'(1);
          if (idx - AW'(1) == lo) begin
            state <= ST_B_END;
          end
        end
        ST_B_END: begin
          if (!swapped || last_swap >= hi) begin
            k     <= '0;
            state <= ST_O_RD;
          end else begin
            lo    <= last_swap;
            state <= ST_F_PRIME;
          end
        end
        ST_O_RD: state <= ST_O_LD;
        ST_O_LD: begin
          result.sorted_value <= $signed(rdata);
          result.last_out     <= (CW'(k) + CW'(1) == count);
          result_valid        <= 1'b1;
          state               <= ST_O_WAIT;
        end
        ST_O_WAIT: begin
          // Hold the item until the receiver takes it.
          if (!result_stall) begin
            result_valid <= 1'b0;
            if (result.last_out) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= ST_O_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
